FILE: design/fbr_pkg.sv
package fbr_pkg;

    // geometry
    localparam int NUM_BLOCKS  = 16;
    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int MAP_DEPTH   = NUM_BLOCKS - 1;
    localparam int MAP_W       = $clog2(MAP_DEPTH);
    localparam int IDX_W       = $clog2(MAP_DEPTH + 1);
    localparam int SECTORS     = 7;
    localparam int CAP_RAW     = MAP_DEPTH * SECTORS;
    localparam logic [6:0] CAPACITY = 7'((CAP_RAW > 127) ? 127 : CAP_RAW);
    localparam logic [15:0] SPARE_TAG = 16'hFFFF;

    // one step per sector (metadata first) plus the erase
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_ERASE = STEP_W'(SECTORS + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request types
    localparam logic [2:0] REQ_BEGIN  = 3'd0;
    localparam logic [2:0] REQ_ENTRY  = 3'd1;
    localparam logic [2:0] REQ_FINISH = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_WRITE  = 3'd4;

    // classified operation kinds
    localparam logic [2:0] KIND_BEGIN  = 3'd0;
    localparam logic [2:0] KIND_ENTRY  = 3'd1;
    localparam logic [2:0] KIND_FINISH = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_WRITE  = 3'd4;
    localparam logic [2:0] KIND_RANGE  = 3'd5;

    // flash commands
    localparam logic [2:0] CMD_STATUS = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_COPY   = 3'd2;
    localparam logic [2:0] CMD_HOST   = 3'd3;
    localparam logic [2:0] CMD_ERASE  = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_BAD_MAP  = 2'd1;
    localparam logic [1:0] STS_RANGE    = 2'd2;
    localparam logic [1:0] STS_NOT_INIT = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  lb;
        logic [2:0]  sec;
        logic [3:0]  pb;
        logic [15:0] tag;
    } t_op;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [3:0]        src;
        logic [3:0]        dst;
        logic signed [3:0] sector;
        logic [1:0]        status;
        logic [6:0]        cap;
        logic              last;
    } t_res;

endpackage

FILE: design/fbr_front.sv
module fbr_front import fbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_logical_block,
    input  logic [2:0]  i_sector,
    input  logic [3:0]  i_phys_block,
    input  logic [15:0] i_meta_tag,
    output logic        o_op_valid,
    output t_op         o_op,
    input  logic        i_op_stall
);

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic n_known;
    logic accept;

    assign o_stall    = r_valid & i_op_stall;
    assign accept     = i_valid & ~o_stall;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    // classify the request; unknown types are dropped here
    always_comb begin
        n_op.lb  = i_logical_block;
        n_op.sec = i_sector;
        n_op.pb  = i_phys_block;
        n_op.tag = i_meta_tag;
        n_op.kind = KIND_BEGIN;
        n_known   = 1'b1;
        case (i_req_type)
            REQ_BEGIN:  n_op.kind = KIND_BEGIN;
            REQ_ENTRY:  n_op.kind = KIND_ENTRY;
            REQ_FINISH: n_op.kind = KIND_FINISH;
            REQ_READ, REQ_WRITE: begin
                if (int'(i_logical_block) >= MAP_DEPTH || int'(i_sector) >= SECTORS) begin
                    n_op.kind = KIND_RANGE;
                end else if (i_req_type == REQ_READ) begin
                    n_op.kind = KIND_READ;
                end else begin
                    n_op.kind = KIND_WRITE;
                end
            end
            default: n_known = 1'b0;
        endcase
    end

    // one registered stage toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_known;
        end else if (!i_op_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

FILE: design/fbr_queue.sv
module fbr_queue import fbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_stall,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_stall,
    output t_op  o_pop_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_stall = (int'(r_count) == QUEUE_DEPTH);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid & ~o_push_stall;
    assign pop          = o_pop_valid & ~i_pop_stall;
    assign o_pop_op     = r_mem[r_rd_ptr];

    // pointer wrap
    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] q;
        q = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

FILE: design/fbr_back.sv
module fbr_back import fbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_valid,
    output logic o_op_stall,
    input  t_op  i_op,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EVICT = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]           r_state;
    logic [BLK_W-1:0]     r_map [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_map_valid;
    logic [BLK_W-1:0]     r_owner [NUM_BLOCKS];
    logic [BLK_W-1:0]     r_spare;
    logic [BLK_W-1:0]     r_rot;
    logic                 r_scan_bad;
    logic                 r_ready;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_chk_bad;
    logic [STEP_W-1:0]    r_step;
    logic [BLK_W-1:0]     r_phys;
    logic [3:0]           r_lb;
    logic [2:0]           r_sec;
    logic                 r_out_valid;
    t_res                 r_out;

    t_res              n_res;
    logic              n_load;
    logic              can_load;
    logic              take;
    logic              chk_done;
    logic              chk_bad_i;
    logic              is_erase;
    logic              evict_needed;
    logic [MAP_W-1:0]  map_addr;
    logic [BLK_W-1:0]  map_rd;
    logic [BLK_W-1:0]  owner_addr;
    logic [BLK_W-1:0]  owner_rd;
    logic [STEP_W-1:0] step_sec;
    logic [BLK_W-1:0]  rot_next;

    assign can_load   = ~r_out_valid | ~i_stall;
    assign take       = (r_state == ST_IDLE) & i_op_valid & can_load;
    assign o_op_stall = ~((r_state == ST_IDLE) & can_load);
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    // map and owner read ports
    assign map_addr   = (r_state == ST_CHECK) ? r_idx[MAP_W-1:0] : i_op.lb[MAP_W-1:0];
    assign map_rd     = r_map[map_addr];
    assign owner_addr = (r_state == ST_CHECK) ? map_rd : r_rot;
    assign owner_rd   = r_owner[owner_addr];

    // map check of one logical block per cycle
    assign chk_done  = (int'(r_idx) == MAP_DEPTH);
    assign chk_bad_i = ~r_map_valid[r_idx[MAP_W-1:0]] | (map_rd == r_spare)
                     | (owner_rd != BLK_W'(r_idx));

    // sector sequencing: step 0 is the metadata sector, last step erases
    assign is_erase     = (r_step == STEP_ERASE);
    assign step_sec     = r_step - STEP_W'(1);
    assign evict_needed = (r_rot != r_spare) && (r_rot != map_rd);
    assign rot_next     = (int'(r_rot) == NUM_BLOCKS - 1) ? '0 : r_rot + BLK_W'(1);

    // result to load into the output register
    always_comb begin
        n_res  = '0;
        n_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_op_valid && can_load) begin
                    n_res.last = 1'b1;
                    case (i_op.kind)
                        KIND_BEGIN, KIND_ENTRY: n_load = 1'b1;
                        KIND_READ: begin
                            n_load = 1'b1;
                            if (!r_ready) begin
                                n_res.status = STS_NOT_INIT;
                            end else begin
                                n_res.cmd    = CMD_READ;
                                n_res.src    = map_rd;
                                n_res.sector = $signed({1'b0, i_op.sec});
                            end
                        end
                        KIND_WRITE: begin
                            if (!r_ready) begin
                                n_load       = 1'b1;
                                n_res.status = STS_NOT_INIT;
                            end
                        end
                        KIND_RANGE: begin
                            n_load       = 1'b1;
                            n_res.status = r_ready ? STS_RANGE : STS_NOT_INIT;
                        end
                        default: n_load = 1'b0;
                    endcase
                end
            end
            ST_CHECK: begin
                if ((r_chk_bad || chk_done) && can_load) begin
                    n_load     = 1'b1;
                    n_res.last = 1'b1;
                    if (r_chk_bad) begin
                        n_res.status = STS_BAD_MAP;
                    end else begin
                        n_res.cap = CAPACITY;
                    end
                end
            end
            ST_EVICT: begin
                if (can_load) begin
                    n_load = 1'b1;
                    if (is_erase) begin
                        n_res.cmd = CMD_ERASE;
                        n_res.src = r_rot;
                    end else begin
                        n_res.cmd    = CMD_COPY;
                        n_res.src    = r_rot;
                        n_res.dst    = r_spare;
                        n_res.sector = $signed(step_sec);
                    end
                end
            end
            ST_WRITE: begin
                if (can_load) begin
                    n_load = 1'b1;
                    if (is_erase) begin
                        n_res.cmd  = CMD_ERASE;
                        n_res.src  = r_phys;
                        n_res.last = 1'b1;
                    end else if (step_sec == {1'b0, r_sec}) begin
                        n_res.cmd    = CMD_HOST;
                        n_res.dst    = r_spare;
                        n_res.sector = $signed(step_sec);
                    end else begin
                        n_res.cmd    = CMD_COPY;
                        n_res.src    = r_phys;
                        n_res.dst    = r_spare;
                        n_res.sector = $signed(step_sec);
                    end
                end
            end
            default: n_load = 1'b0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out <= n_res;
        end
    end

    // control state, translation state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map_valid <= '0;
            r_spare     <= '0;
            r_rot       <= '0;
            r_scan_bad  <= 1'b0;
            r_ready     <= 1'b0;
            r_idx       <= '0;
            r_chk_bad   <= 1'b0;
            r_step      <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        case (i_op.kind)
                            KIND_BEGIN: begin
                                r_map_valid <= '0;
                                r_scan_bad  <= 1'b0;
                                r_ready     <= 1'b0;
                            end
                            KIND_ENTRY: begin
                                r_ready <= 1'b0;
                                if (int'(i_op.pb) < NUM_BLOCKS) begin
                                    if (i_op.tag == SPARE_TAG) begin
                                        r_spare <= i_op.pb[BLK_W-1:0];
                                    end else if (int'(i_op.tag) < MAP_DEPTH) begin
                                        r_map[i_op.tag[MAP_W-1:0]]       <= i_op.pb[BLK_W-1:0];
                                        r_map_valid[i_op.tag[MAP_W-1:0]] <= 1'b1;
                                        r_owner[i_op.pb[BLK_W-1:0]]      <= i_op.tag[BLK_W-1:0];
                                    end else begin
                                        r_scan_bad <= 1'b1;
                                    end
                                end
                            end
                            KIND_FINISH: begin
                                r_chk_bad <= r_scan_bad;
                                r_idx     <= '0;
                                r_state   <= ST_CHECK;
                            end
                            KIND_WRITE: begin
                                if (r_ready) begin
                                    r_phys  <= map_rd;
                                    r_lb    <= i_op.lb;
                                    r_sec   <= i_op.sec;
                                    r_step  <= '0;
                                    r_state <= evict_needed ? ST_EVICT : ST_WRITE;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_CHECK: begin
                    if (r_chk_bad || chk_done) begin
                        if (can_load) begin
                            r_ready <= ~r_chk_bad;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_chk_bad <= chk_bad_i;
                        r_idx     <= r_idx + IDX_W'(1);
                    end
                end
                ST_EVICT: begin
                    if (can_load) begin
                        if (is_erase) begin
                            // rotated block now lives in the old spare
                            if (int'(owner_rd) < MAP_DEPTH) begin
                                r_map[owner_rd[MAP_W-1:0]] <= r_spare;
                            end
                            r_owner[r_spare] <= owner_rd;
                            r_spare          <= r_rot;
                            r_step           <= '0;
                            r_state          <= ST_WRITE;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                ST_WRITE: begin
                    if (can_load) begin
                        if (is_erase) begin
                            r_map[r_lb[MAP_W-1:0]] <= r_spare;
                            r_owner[r_spare]       <= r_lb[BLK_W-1:0];
                            r_spare                <= r_phys;
                            r_rot                  <= rot_next;
                            r_state                <= ST_IDLE;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: design/flash_block_remapper_unit.sv
// Block-level flash translation with one spare block and round-robin wear
// leveling. Begin scan, scan entry, a read, or a refused request each give one
// result item. Finish scan checks one logical block per cycle and then loads its
// status item; a bad map ends the check early. A write gives nine items (eight
// sector moves and an erase), or eighteen when the block under the rotate
// pointer is first evicted into the spare; the sequencer issues one flash
// command per cycle while the receiver does not stall, after the cycle that
// takes the write. A two-entry queue after the classifying front end lets new
// items arrive while a write is still being sequenced. Request types 5 to 7 are
// accepted and give no result. Sector data itself does not pass here.
module flash_block_remapper_unit import fbr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_req_type,
    input  logic [3:0]        i_logical_block,
    input  logic [2:0]        i_sector,
    input  logic [3:0]        i_phys_block,
    input  logic [15:0]       i_meta_tag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_cmd,
    output logic [3:0]        o_src_block,
    output logic [3:0]        o_dest_block,
    output logic signed [3:0] o_flash_sector,
    output logic [1:0]        o_status,
    output logic [6:0]        o_capacity,
    output logic              o_last
);

    logic f_valid;
    logic f_stall;
    t_op  f_op;
    logic q_valid;
    logic q_stall;
    t_op  q_op;
    t_res res;

    // classify incoming items
    fbr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_logical_block (i_logical_block),
        .i_sector        (i_sector),
        .i_phys_block    (i_phys_block),
        .i_meta_tag      (i_meta_tag),
        .o_op_valid      (f_valid),
        .o_op            (f_op),
        .i_op_stall      (f_stall)
    );

    // decoupling queue
    fbr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_stall (f_stall),
        .i_push_op    (f_op),
        .o_pop_valid  (q_valid),
        .i_pop_stall  (q_stall),
        .o_pop_op     (q_op)
    );

    // translation state and command sequencer
    fbr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .o_op_stall (q_stall),
        .i_op       (q_op),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (res)
    );

    assign o_cmd          = res.cmd;
    assign o_src_block    = res.src;
    assign o_dest_block   = res.dst;
    assign o_flash_sector = res.sector;
    assign o_status       = res.status;
    assign o_capacity     = res.cap;
    assign o_last         = res.last;

endmodule

FILE: test/flash_block_remapper_checker.sv
module flash_block_remapper_checker import fbr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_req_valid,
    input  logic              i_req_stall,
    input  logic [2:0]        i_req_type,
    input  logic [3:0]        i_logical_block,
    input  logic [2:0]        i_sector,
    input  logic [3:0]        i_phys_block,
    input  logic [15:0]       i_meta_tag,
    // flash command channel
    input  logic              i_rsp_valid,
    input  logic              i_rsp_stall,
    input  logic [2:0]        i_cmd,
    input  logic [3:0]        i_src_block,
    input  logic [3:0]        i_dest_block,
    input  logic signed [3:0] i_flash_sector,
    input  logic [1:0]        i_status,
    input  logic [6:0]        i_capacity,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending
);

    // shadow of the translation state
    logic [BLK_W-1:0] lmap [MAP_DEPTH];
    logic             lmap_ok [MAP_DEPTH];
    logic [BLK_W-1:0] owner [NUM_BLOCKS];
    logic [BLK_W-1:0] spare;
    logic [BLK_W-1:0] rot;
    logic             scan_err;
    logic             ready;

    t_res flash_cmds_due [$];
    int   mismatches = 0;
    int   cmds_seen = 0;
    int   due_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = due_count;

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("checker: flash command %0d: %s", cmds_seen, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic push_cmd(input logic [2:0] cmd, input logic [3:0] src,
                            input logic [3:0] dst, input int sec,
                            input logic [1:0] sts, input logic [6:0] cap,
                            input logic fin);
        t_res r;
        r.cmd    = cmd;
        r.src    = src;
        r.dst    = dst;
        r.sector = 4'(sec);
        r.status = sts;
        r.cap    = cap;
        r.last   = fin;
        flash_cmds_due.push_back(r);
    endtask

    // expected flash commands for one accepted request
    task automatic predict_request(input logic [2:0] req, input logic [3:0] lblk,
                                   input logic [2:0] sect, input logic [3:0] pblk,
                                   input logic [15:0] mtag);
        logic             bad;
        logic [BLK_W-1:0] here;
        logic [BLK_W-1:0] moved_owner;
        int               i;
        int               s;
        case (req)
            REQ_BEGIN: begin
                for (i = 0; i < MAP_DEPTH; i++)
                    lmap_ok[i] = 1'b0;
                scan_err = 1'b0;
                ready    = 1'b0;
                push_cmd(CMD_STATUS, 0, 0, 0, STS_OK, 0, 1'b1);
            end
            REQ_ENTRY: begin
                ready = 1'b0;
                if (mtag == SPARE_TAG) begin
                    spare = pblk;
                end else if (mtag < MAP_DEPTH) begin
                    lmap[mtag[BLK_W-1:0]]    = pblk;
                    lmap_ok[mtag[BLK_W-1:0]] = 1'b1;
                    owner[pblk]              = mtag[BLK_W-1:0];
                end else begin
                    scan_err = 1'b1;
                end
                push_cmd(CMD_STATUS, 0, 0, 0, STS_OK, 0, 1'b1);
            end
            REQ_FINISH: begin
                // every logical block mapped once, off the spare, owner agreeing
                bad = scan_err;
                for (i = 0; i < MAP_DEPTH; i++)
                    if (!lmap_ok[i] || lmap[i] == spare || owner[lmap[i]] != BLK_W'(i))
                        bad = 1'b1;
                ready = !bad;
                if (bad)
                    push_cmd(CMD_STATUS, 0, 0, 0, STS_BAD_MAP, 0, 1'b1);
                else
                    push_cmd(CMD_STATUS, 0, 0, 0, STS_OK, CAPACITY, 1'b1);
            end
            REQ_READ, REQ_WRITE: begin
                if (!ready) begin
                    push_cmd(CMD_STATUS, 0, 0, 0, STS_NOT_INIT, 0, 1'b1);
                end else if (lblk >= MAP_DEPTH || sect >= SECTORS) begin
                    push_cmd(CMD_STATUS, 0, 0, 0, STS_RANGE, 0, 1'b1);
                end else if (req == REQ_READ) begin
                    push_cmd(CMD_READ, lmap[lblk], 0, int'(sect), STS_OK, 0, 1'b1);
                end else begin
                    here = lmap[lblk];
                    // wear leveling: move the block under the pointer into the spare
                    if (rot != spare && rot != here) begin
                        for (s = -1; s < SECTORS; s++)
                            push_cmd(CMD_COPY, rot, spare, s, STS_OK, 0, 1'b0);
                        push_cmd(CMD_ERASE, rot, 0, 0, STS_OK, 0, 1'b0);
                        moved_owner = owner[rot];
                        if (moved_owner < MAP_DEPTH)
                            lmap[moved_owner] = spare;
                        owner[spare] = moved_owner;
                        spare = rot;
                    end
                    // copy target into spare with the host sector merged in
                    for (s = -1; s < SECTORS; s++) begin
                        if (s == int'(sect))
                            push_cmd(CMD_HOST, 0, spare, s, STS_OK, 0, 1'b0);
                        else
                            push_cmd(CMD_COPY, here, spare, s, STS_OK, 0, 1'b0);
                    end
                    push_cmd(CMD_ERASE, here, 0, 0, STS_OK, 0, 1'b1);
                    lmap[lblk]   = spare;
                    owner[spare] = lblk;
                    spare        = here;
                    rot          = BLK_W'((int'(rot) + 1) % NUM_BLOCKS);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_res want;
        if (flash_cmds_due.size() == 0) begin
            report_mismatch($sformatf("unexpected item, cmd %0d", i_cmd));
        end else begin
            want = flash_cmds_due.pop_front();
            compare_field("cmd", 16'(i_cmd), 16'(want.cmd));
            compare_field("src_block", 16'(i_src_block), 16'(want.src));
            compare_field("dest_block", 16'(i_dest_block), 16'(want.dst));
            compare_field("flash_sector", 16'(unsigned'(i_flash_sector)),
                          16'(unsigned'(want.sector)));
            compare_field("status", 16'(i_status), 16'(want.status));
            compare_field("capacity", 16'(i_capacity), 16'(want.cap));
            compare_field("last", 16'(i_last), 16'(want.last));
        end
        cmds_seen++;
    endtask

    // results first: nothing leaving now can stem from a request taken now
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_DEPTH; i++) begin
                lmap[i]    = '0;
                lmap_ok[i] = 1'b0;
            end
            for (int i = 0; i < NUM_BLOCKS; i++)
                owner[i] = '0;
            spare    = '0;
            rot      = '0;
            scan_err = 1'b0;
            ready    = 1'b0;
            flash_cmds_due.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall)
                check_result();
            if (i_req_valid && !i_req_stall)
                predict_request(i_req_type, i_logical_block, i_sector, i_phys_block,
                                i_meta_tag);
        end
        due_count <= flash_cmds_due.size();
    end

endmodule

FILE: test/tb_flash_block_remapper_unit.sv
module tb_flash_block_remapper_unit;
    import fbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 360;
    localparam int CALM_TAIL      = 80;
    localparam int DRAIN_CYCLES   = 40;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_SHARED,
        FLAW_ON_SPARE,
        FLAW_MISSING,
        FLAW_BAD_TAG
    } t_scan_flaw;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [2:0]        i_req_type = '0;
    logic [3:0]        i_logical_block = '0;
    logic [2:0]        i_sector = '0;
    logic [3:0]        i_phys_block = '0;
    logic [15:0]       i_meta_tag = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_cmd;
    logic [3:0]        o_src_block;
    logic [3:0]        o_dest_block;
    logic signed [3:0] o_flash_sector;
    logic [1:0]        o_status;
    logic [6:0]        o_capacity;
    logic              o_last;

    int fail_count;
    int cmds_pending;
    int host_items = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    bit calm = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    flash_block_remapper_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_logical_block (i_logical_block),
        .i_sector        (i_sector),
        .i_phys_block    (i_phys_block),
        .i_meta_tag      (i_meta_tag),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cmd           (o_cmd),
        .o_src_block     (o_src_block),
        .o_dest_block    (o_dest_block),
        .o_flash_sector  (o_flash_sector),
        .o_status        (o_status),
        .o_capacity      (o_capacity),
        .o_last          (o_last)
    );

    flash_block_remapper_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_type      (i_req_type),
        .i_logical_block (i_logical_block),
        .i_sector        (i_sector),
        .i_phys_block    (i_phys_block),
        .i_meta_tag      (i_meta_tag),
        .i_rsp_valid     (o_valid),
        .i_rsp_stall     (i_stall),
        .i_cmd           (o_cmd),
        .i_src_block     (o_src_block),
        .i_dest_block    (o_dest_block),
        .i_flash_sector  (o_flash_sector),
        .i_status        (o_status),
        .i_capacity      (o_capacity),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (cmds_pending)
    );

    // receiver back-pressure in bursts; a new burst starts only after stall has dropped
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && !i_stall && stall_pct > 0
                     && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles where neither channel moves an item
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("flash_block_remapper_unit regression: fail");
            $finish;
        end
    end

    // one item, with an optional gap ahead of it; valid stays high afterwards
    task automatic send_item(input logic [2:0] req, input logic [3:0] lblk,
                             input logic [2:0] sect, input logic [3:0] pblk,
                             input logic [15:0] mtag);
        if (!calm && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_logical_block <= lblk;
        i_sector        <= sect;
        i_phys_block    <= pblk;
        i_meta_tag      <= mtag;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (req <= REQ_WRITE)
            host_items++;
    endtask

    task automatic send_host(input logic [2:0] req, input logic [3:0] lblk,
                             input logic [2:0] sect);
        send_item(req, lblk, sect, 4'($urandom), 16'($urandom));
    endtask

    task automatic send_entry(input logic [3:0] pblk, input logic [15:0] mtag);
        send_item(REQ_ENTRY, 4'($urandom), 3'($urandom), pblk, mtag);
    endtask

    // scan of all physical blocks in random order, optionally flawed
    task automatic load_map(input t_scan_flaw flaw, input bit with_begin,
                            input bit with_finish);
        logic [3:0] phys_of [NUM_BLOCKS];
        int         visit [NUM_BLOCKS];
        logic [3:0] t;
        int         i;
        int         j;
        int         k;
        int         victim;
        int         other;
        for (i = 0; i < NUM_BLOCKS; i++) begin
            phys_of[i] = 4'(i);
            visit[i]   = i;
        end
        for (i = NUM_BLOCKS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = phys_of[i];
            phys_of[i] = phys_of[j];
            phys_of[j] = t;
            j = $urandom_range(i);
            k = visit[i];
            visit[i] = visit[j];
            visit[j] = k;
        end
        // logical block i lives on phys_of[i]; the spare is phys_of[MAP_DEPTH]
        victim = $urandom_range(MAP_DEPTH - 1);
        other  = (victim + 1 + $urandom_range(MAP_DEPTH - 2)) % MAP_DEPTH;
        if (flaw == FLAW_SHARED)
            phys_of[victim] = phys_of[other];
        if (flaw == FLAW_ON_SPARE)
            phys_of[victim] = phys_of[MAP_DEPTH];
        if (with_begin)
            send_host(REQ_BEGIN, 4'($urandom), 3'($urandom));
        for (i = 0; i < NUM_BLOCKS; i++) begin
            k = visit[i];
            if (k == MAP_DEPTH)
                send_entry(phys_of[k], SPARE_TAG);
            else if (!(flaw == FLAW_MISSING && k == victim))
                send_entry(phys_of[k], 16'(k));
            if (flaw == FLAW_BAD_TAG && i == victim)
                send_entry(4'($urandom), 16'($urandom_range(MAP_DEPTH, 16'hFFFE)));
        end
        if (with_finish)
            send_host(REQ_FINISH, 4'($urandom), 3'($urandom));
    endtask

    // host traffic on a loaded map, with a little noise mixed in
    task automatic host_traffic();
        logic [3:0] lblk;
        logic [2:0] sect;
        int         pick;
        lblk = ($urandom_range(9) == 0) ? 4'd15 : 4'($urandom_range(MAP_DEPTH - 1));
        sect = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(SECTORS - 1));
        pick = $urandom_range(99);
        if (pick < 3)
            send_item(3'($urandom), 4'($urandom), 3'($urandom), 4'($urandom),
                      16'($urandom));
        else if (pick < 48)
            send_host(REQ_READ, lblk, sect);
        else
            send_host(REQ_WRITE, lblk, sect);
    endtask

    initial begin
        int         stop_at;
        int         pick;
        t_scan_flaw flaw;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: requests before any map, ignored request types
        send_host(REQ_READ, 4'd0, 3'd0);
        send_host(REQ_WRITE, 4'd15, 3'd7);
        send_item(3'd5, 4'd0, 3'd0, 4'd0, 16'h0000);
        send_item(3'd6, 4'd15, 3'd7, 4'd15, 16'hFFFF);
        send_item(3'd7, 4'd5, 3'd2, 4'd10, 16'h5A5A);

        // directed: bad tags spoil the scan
        send_host(REQ_BEGIN, 4'd0, 3'd0);
        send_entry(4'd0, 16'hFFFE);
        send_entry(4'd15, 16'(MAP_DEPTH));
        send_entry(4'd7, SPARE_TAG);
        send_host(REQ_FINISH, 4'd0, 3'd0);

        // directed: good map, then range errors and the field extremes
        load_map(FLAW_NONE, 1'b1, 1'b1);
        send_host(REQ_READ, 4'd15, 3'd0);
        send_host(REQ_READ, 4'd0, 3'd7);
        send_host(REQ_WRITE, 4'd15, 3'd6);
        send_host(REQ_WRITE, 4'd14, 3'd7);
        send_host(REQ_READ, 4'd14, 3'd6);
        send_host(REQ_WRITE, 4'd0, 3'd0);
        send_host(REQ_WRITE, 4'd14, 3'd6);
        send_host(REQ_READ, 4'd0, 3'd0);

        // random phases: mostly good scans followed by host traffic
        stop_at = host_items + RANDOM_ITEMS;
        while (host_items < stop_at) begin
            calm = (host_items >= stop_at - CALM_TAIL);
            case ($urandom_range(3))
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 15; stall_pct = 15; end
                2: begin gap_pct = 40; stall_pct = 10; end
                default: begin gap_pct = 10; stall_pct = 45; end
            endcase
            pick = $urandom_range(99);
            if (pick < 65)
                flaw = FLAW_NONE;
            else
                flaw = t_scan_flaw'($urandom_range(1, 4));
            load_map(flaw, $urandom_range(9) != 0, $urandom_range(19) != 0);
            repeat ($urandom_range(6, 24)) begin
                calm = (host_items >= stop_at - CALM_TAIL);
                host_traffic();
            end
        end

        // drain
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (cmds_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("flash_block_remapper_unit regression: pass");
        else
            $display("flash_block_remapper_unit regression: fail");
        $finish;
    end

endmodule

FILE: flash_block_remapper_unit.f
design/fbr_pkg.sv
design/fbr_front.sv
design/fbr_queue.sv
design/fbr_back.sv
design/flash_block_remapper_unit.sv
test/flash_block_remapper_checker.sv
test/tb_flash_block_remapper_unit.sv
